// ----- src/upd_pkg.sv -----
// Shared types and constants for the URL path segment decoder.
`timescale 1ns / 1ps

package upd_pkg;

  // Depth of the queue between the classifying front and the result back.
  localparam int UPD_FIFO_DEPTH = 4;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;
  localparam int OUT_USER_W = 2;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_SEG  = 2'd1,
    KIND_END  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_NO_SLASH = 3'd1,
    ERR_RAW      = 3'd2,
    ERR_ESCAPE   = 3'd3,
    ERR_DECODED  = 3'd4,
    ERR_DOT      = 3'd5,
    ERR_UTF8     = 3'd6
  } err_t;

  // Everything one accepted item causes: an optional byte or segment end,
  // then an optional path end with its status.
  typedef struct packed {
    logic       has_first;
    kind_t      first_kind;
    logic [7:0] first_byte;
    logic       has_end;
    logic       end_ok;
    err_t       end_err;
  } rec_t;

  // One result on the output channel.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       ok;
    err_t       err;
    logic       last;
  } res_t;

endpackage

// ----- src/url_path_segment_decoder.sv -----
// Top level of the URL path segment decoder: front, queue and back joined.
`timescale 1ns / 1ps

// The block takes a request path one raw byte per item on the slave stream
// (s_tdata holds the byte, s_tlast marks the last item of a path, s_tuser
// marks an item that carries no byte and ends an empty path). It returns
// decoded bytes, segment-end marks and one path-end status item per path on
// the master stream; m_tlast marks the last result that one input item caused.
// Every item is classified in the cycle it is accepted, so a byte is taken in
// every cycle while the queue has room; an item that causes two results (a byte
// or segment end followed by the path end) takes two transfers on the output.
// The first result of an item passes through the queue and then the output
// register before it shows on m_tvalid. A four-entry queue of result records
// separates the classifying front from the output register, so s_tready stays
// high while the receiver stalls until that queue fills.
// Reset clears the decoding state, the queue and the output valid flags; the
// block then waits for the leading slash of a new path. After every path end
// the decoding state returns to its reset values.
module url_path_segment_decoder #(
  parameter int FifoDepth = upd_pkg::UPD_FIFO_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [upd_pkg::IN_DATA_W-1:0] s_tdata,   // [7:0] path_byte
  input  logic                          s_tlast,   // end_of_path
  input  logic                          s_tuser,   // empty_path
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [upd_pkg::OUT_DATA_W-1:0] m_tdata,  // [7:0] out_byte, [8] path_ok,
                                                   // [11:9] error_code, [15:12] zero
  output logic                          m_tlast,   // last_result
  output logic [upd_pkg::OUT_USER_W-1:0] m_tuser   // [1:0] out_kind
);
  import upd_pkg::*;

  rec_t push_rec;
  rec_t pop_rec;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  res_t res;

  upd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_rec    (push_rec)
  );

  upd_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_rec (push_rec),
    .pop    (q_pop),
    .rd_rec (pop_rec),
    .full   (q_full),
    .empty  (q_empty)
  );

  upd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_rec    (pop_rec),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .res      (res)
  );

  // Results are packed with the byte lowest, then the status bit and code.
  assign m_tdata = {4'b0000, res.err, res.ok, res.data};
  assign m_tuser = res.kind;
  assign m_tlast = res.last;

endmodule

// ----- src/upd_front.sv -----
// Front end: accepts raw path bytes, runs the decoding checks and queues results.
`timescale 1ns / 1ps

module upd_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,
  input  logic             s_tlast,
  input  logic             s_tuser,
  input  logic             q_full,
  output logic             q_push,
  output upd_pkg::rec_t    q_rec
);
  import upd_pkg::*;

  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_HIGH = 2'd1,
    ESC_LOW  = 2'd2
  } esc_t;

  typedef enum logic [1:0] {
    DOT_EMPTY = 2'd0,
    DOT_ONE   = 2'd1,
    DOT_TWO   = 2'd2,
    DOT_OTHER = 2'd3
  } dot_t;

  // Range allowed for the next UTF-8 continuation byte.
  typedef enum logic [2:0] {
    RNG_ANY   = 3'd0,
    RNG_A0_BF = 3'd1,
    RNG_80_9F = 3'd2,
    RNG_90_BF = 3'd3,
    RNG_80_8F = 3'd4
  } rng_t;

  localparam logic [7:0] CHAR_SLASH     = 8'h2F;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_PERCENT   = 8'h25;
  localparam logic [7:0] CHAR_QUESTION  = 8'h3F;
  localparam logic [7:0] CHAR_HASH      = 8'h23;
  localparam logic [7:0] CHAR_DOT       = 8'h2E;
  localparam logic [7:0] CHAR_DEL       = 8'h7F;
  localparam logic [7:0] CHAR_SPACE     = 8'h20;
  localparam logic [7:0] CHAR_BANG      = 8'h21;

  logic       started,        started_next;
  esc_t       escape_phase,   escape_phase_next;
  logic [3:0] high_nibble,    high_nibble_next;
  dot_t       dot_status,     dot_status_next;
  logic [1:0] utf8_remaining, utf8_remaining_next;
  rng_t       utf8_range,     utf8_range_next;
  err_t       first_error,    first_error_next;

  logic accept;

  // Bit 4 set means the byte is not a hex digit.
  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    logic [4:0] r;
    r = 5'h10;
    if (b >= 8'h30 && b <= 8'h39) r = {1'b0, 4'(b - 8'h30)};
    else if (b >= 8'h61 && b <= 8'h66) r = {1'b0, 4'(b - 8'h57)};
    else if (b >= 8'h41 && b <= 8'h46) r = {1'b0, 4'(b - 8'h37)};
    return r;
  endfunction

  // Checks that close a segment; gives the error found or none.
  function automatic err_t close_check(input esc_t esc, input dot_t dot,
                                       input logic [1:0] rem);
    err_t r;
    r = ERR_NONE;
    if (esc != ESC_NONE) r = ERR_ESCAPE;
    else if (dot == DOT_ONE || dot == DOT_TWO) r = ERR_DOT;
    else if (rem != 2'd0) r = ERR_UTF8;
    return r;
  endfunction

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  always_comb begin : step_logic
    logic [4:0] hx;
    logic [7:0] d;
    logic       take;
    logic       bad;
    logic [7:0] lo;
    logic [7:0] hi;
    err_t       c;

    started_next        = started;
    escape_phase_next   = escape_phase;
    high_nibble_next    = high_nibble;
    dot_status_next     = dot_status;
    utf8_remaining_next = utf8_remaining;
    utf8_range_next     = utf8_range;
    first_error_next    = first_error;
    q_rec               = '0;
    hx                  = hex_decode(s_tdata);
    d                   = s_tdata;
    take                = 1'b0;
    bad                 = 1'b0;
    lo                  = 8'h80;
    hi                  = 8'hBF;
    c                   = ERR_NONE;

    if (!s_tuser && first_error == ERR_NONE) begin
      if (!started) begin
        if (s_tdata == CHAR_SLASH) started_next = 1'b1;
        else first_error_next = ERR_NO_SLASH;
      end else if (escape_phase != ESC_NONE) begin
        if (hx[4]) begin
          first_error_next = ERR_ESCAPE;
        end else if (escape_phase == ESC_HIGH) begin
          high_nibble_next  = hx[3:0];
          escape_phase_next = ESC_LOW;
        end else begin
          escape_phase_next = ESC_NONE;
          d = {high_nibble, hx[3:0]};
          if (d < CHAR_SPACE || d == CHAR_DEL || d == CHAR_SLASH || d == CHAR_BACKSLASH)
            first_error_next = ERR_DECODED;
          else
            take = 1'b1;
        end
      end else if (s_tdata == CHAR_SLASH) begin
        c = close_check(escape_phase, dot_status, utf8_remaining);
        if (c != ERR_NONE) begin
          first_error_next = c;
        end else begin
          dot_status_next  = DOT_EMPTY;
          utf8_range_next  = RNG_ANY;
          q_rec.has_first  = 1'b1;
          q_rec.first_kind = KIND_SEG;
        end
      end else if (s_tdata < CHAR_BANG || s_tdata >= CHAR_DEL || s_tdata == CHAR_QUESTION ||
                   s_tdata == CHAR_HASH || s_tdata == CHAR_BACKSLASH) begin
        first_error_next = ERR_RAW;
      end else if (s_tdata == CHAR_PERCENT) begin
        escape_phase_next = ESC_HIGH;
      end else begin
        take = 1'b1;
      end
    end

    // A decoded byte goes through the UTF-8 and dot-segment tracking.
    if (take) begin
      if (utf8_remaining != 2'd0) begin
        unique case (utf8_range)
          RNG_A0_BF: lo = 8'hA0;
          RNG_80_9F: hi = 8'h9F;
          RNG_90_BF: lo = 8'h90;
          RNG_80_8F: hi = 8'h8F;
          default: ;
        endcase
        if (d < lo || d > hi) begin
          bad = 1'b1;
        end else begin
          utf8_range_next     = RNG_ANY;
          utf8_remaining_next = utf8_remaining - 2'd1;
        end
      end else begin
        utf8_range_next = RNG_ANY;
        if (d < 8'h80) begin
          bad = 1'b0;
        end else if (d >= 8'hC2 && d <= 8'hDF) begin
          utf8_remaining_next = 2'd1;
        end else if (d >= 8'hE0 && d <= 8'hEF) begin
          utf8_remaining_next = 2'd2;
          if (d == 8'hE0) utf8_range_next = RNG_A0_BF;
          else if (d == 8'hED) utf8_range_next = RNG_80_9F;
        end else if (d >= 8'hF0 && d <= 8'hF4) begin
          utf8_remaining_next = 2'd3;
          if (d == 8'hF0) utf8_range_next = RNG_90_BF;
          else if (d == 8'hF4) utf8_range_next = RNG_80_8F;
        end else begin
          bad = 1'b1;
        end
      end
      if (bad) begin
        first_error_next = ERR_UTF8;
      end else begin
        if (d == CHAR_DOT && dot_status == DOT_EMPTY) dot_status_next = DOT_ONE;
        else if (d == CHAR_DOT && dot_status == DOT_ONE) dot_status_next = DOT_TWO;
        else dot_status_next = DOT_OTHER;
        q_rec.has_first  = 1'b1;
        q_rec.first_kind = KIND_BYTE;
        q_rec.first_byte = d;
      end
    end

    // Path end closes the final segment and returns everything to reset.
    if (s_tuser || s_tlast) begin
      if (first_error_next == ERR_NONE) begin
        if (!started_next) begin
          first_error_next = ERR_NO_SLASH;
        end else begin
          c = close_check(escape_phase_next, dot_status_next, utf8_remaining_next);
          if (c != ERR_NONE) first_error_next = c;
        end
      end
      q_rec.has_end       = 1'b1;
      q_rec.end_ok        = (first_error_next == ERR_NONE);
      q_rec.end_err       = first_error_next;
      started_next        = 1'b0;
      escape_phase_next   = ESC_NONE;
      high_nibble_next    = 4'd0;
      dot_status_next     = DOT_EMPTY;
      utf8_remaining_next = 2'd0;
      utf8_range_next     = RNG_ANY;
      first_error_next    = ERR_NONE;
    end
  end

  assign q_push = accept && (q_rec.has_first || q_rec.has_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      started        <= 1'b0;
      escape_phase   <= ESC_NONE;
      high_nibble    <= 4'd0;
      dot_status     <= DOT_EMPTY;
      utf8_remaining <= 2'd0;
      utf8_range     <= RNG_ANY;
      first_error    <= ERR_NONE;
    end else if (accept) begin
      started        <= started_next;
      escape_phase   <= escape_phase_next;
      high_nibble    <= high_nibble_next;
      dot_status     <= dot_status_next;
      utf8_remaining <= utf8_remaining_next;
      utf8_range     <= utf8_range_next;
      first_error    <= first_error_next;
    end
  end

endmodule

// ----- src/upd_fifo.sv -----
// Short queue of per-item result records between the front and the back.
`timescale 1ns / 1ps

module upd_fifo #(
  parameter int Depth = upd_pkg::UPD_FIFO_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  upd_pkg::rec_t wr_rec,
  input  logic          pop,
  output upd_pkg::rec_t rd_rec,
  output logic          full,
  output logic          empty
);
  import upd_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  rec_t            entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full   = (count == FullCnt);
  assign empty  = (count == '0);
  assign rd_rec = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= wr_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full && !pop |-> !push) else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    empty |-> !pop) else $error("queue read while empty");

endmodule

// ----- src/upd_back.sv -----
// Back end: turns queued records into results behind an output register.
`timescale 1ns / 1ps

module upd_back (
  input  logic          clk,
  input  logic          rst,
  input  upd_pkg::rec_t q_rec,
  input  logic          q_empty,
  output logic          q_pop,
  output logic          m_tvalid,
  input  logic          m_tready,
  output upd_pkg::res_t res
);
  import upd_pkg::*;

  logic out_valid;
  logic pend_valid;
  res_t pend;
  res_t first_res;
  res_t end_res;
  logic out_free;

  assign out_free = !out_valid || m_tready;
  assign q_pop    = out_free && !pend_valid && !q_empty;
  assign m_tvalid = out_valid;

  always_comb begin
    end_res.kind = KIND_END;
    end_res.data = 8'd0;
    end_res.ok   = q_rec.end_ok;
    end_res.err  = q_rec.end_err;
    end_res.last = 1'b1;
    if (q_rec.has_first) begin
      first_res.kind = q_rec.first_kind;
      first_res.data = q_rec.first_byte;
      first_res.ok   = 1'b0;
      first_res.err  = ERR_NONE;
      first_res.last = !q_rec.has_end;
    end else begin
      first_res = end_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (out_free) begin
      if (pend_valid) begin
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else begin
        out_valid  <= !q_empty;
        pend_valid <= !q_empty && q_rec.has_first && q_rec.has_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (pend_valid) begin
        res <= pend;
      end else if (!q_empty) begin
        res  <= first_res;
        pend <= end_res;
      end
    end
  end

  a_pend_behind_out: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> out_valid) else $error("pending path end without a shown result");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.kind == KIND_END |-> res.last) else $error("path end not marked last");

  a_status_only_at_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.kind != KIND_END |-> !res.ok && res.err == ERR_NONE)
    else $error("status on a result that is not a path end");

  a_pend_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && pend_valid |-> !res.last) else $error("result before path end marked last");

endmodule
